// File: hw/rtl/bpa_pkg.sv
// shared types, constants and helper functions for the two-pool bitmap page allocator
package bpa_pkg;

    // default pool geometry
    localparam int LOW_POOL_WORDS_DEF        = 20;
    localparam int DMA_POOL_WORDS_DEF        = 512;
    localparam int DMA_FIRST_SEARCH_WORD_DEF = 3;

    // bitmap and address layout
    localparam int MAP_W       = 64;
    localparam int BIT_IDX_W   = 6;
    localparam int ADDR_W      = 32;
    localparam int PAGE_ADDR_W = 28;
    localparam int PAGE_SHIFT  = 12;
    localparam int WORD_SHIFT  = 18;
    localparam int WORD_IDX_W  = ADDR_W - WORD_SHIFT;

    localparam logic [ADDR_W-1:0] DMA_BASE      = 32'h0010_0000;
    localparam logic [MAP_W-1:0]  LOW_WORD0_RST = ~64'hF;

    // request codes
    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_FREE   = 1'b1;
    localparam logic POOL_LOW  = 1'b0;
    localparam logic POOL_DMA  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_STEP,
        S_UPDATE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic look;
        logic step;
        logic update;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic dma_alloc;
    } dp_status_t;

    // index of the lowest set bit, 0 for an all-zero word
    function automatic logic [BIT_IDX_W-1:0] first_set64(input logic [MAP_W-1:0] v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: hw/rtl/bitmap_page_allocator_two_pools.sv
// top level of the two-pool first-fit bitmap page allocator
//
// Keeps free-page bitmaps (one bit per 4 KiB page, 1 = free) for a low pool based at
// address 0 and a dma pool based at 1 MiB, each in a ram of 64-bit words. An allocate
// word takes the lowest free page of the first nonempty word (dma search starts at
// DMA_FIRST_SEARCH_WORD) and returns its byte address with ok set, or address 0 with ok
// clear when the pool is empty. A free word sets the page's bit and returns ok, or ok
// clear when the address is outside the pool. After reset the block runs a clearing pass
// that writes the reset bitmaps; no request word is taken during it. Requests are
// handled one at a time, each a read-modify-write of one bitmap ram word plus, for a dma
// allocate, one extra read of the group summary ram. Flip-flop summary bits (one per low
// word, one per group of 64 dma words) steer the search straight to a nonempty word, so
// the time does not depend on fill level. The finished result sits in an output register,
// so the next request word is taken while the result waits for the downstream side.
module bitmap_page_allocator_two_pools #(
    parameter int LOW_POOL_WORDS        = bpa_pkg::LOW_POOL_WORDS_DEF,
    parameter int DMA_POOL_WORDS        = bpa_pkg::DMA_POOL_WORDS_DEF,
    parameter int DMA_FIRST_SEARCH_WORD = bpa_pkg::DMA_FIRST_SEARCH_WORD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] address
    input  logic [1:0]  s_axis_tuser,   // [0] operation, [1] pool
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [27:0] page_address, [31:28] zero
    output logic        m_axis_tuser    // [0] ok
);

    import bpa_pkg::*;

    dp_cmd_t                cmd;
    dp_status_t             status;
    logic [PAGE_ADDR_W-1:0] page_address;
    logic                   ok;

    // sequencing: clearing pass, lookup, optional group step, write-back, output load
    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // bitmap rams, summary bits and result registers
    bpa_dp #(
        .LOW_POOL_WORDS        (LOW_POOL_WORDS),
        .DMA_POOL_WORDS        (DMA_POOL_WORDS),
        .DMA_FIRST_SEARCH_WORD (DMA_FIRST_SEARCH_WORD)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (s_axis_tuser[0]),
        .pool         (s_axis_tuser[1]),
        .address      (s_axis_tdata),
        .page_address (page_address),
        .ok           (ok)
    );

    // pad the 28-bit page address to a whole number of bytes
    assign m_axis_tdata = {{(32 - PAGE_ADDR_W){1'b0}}, page_address};
    assign m_axis_tuser = ok;

endmodule

// File: hw/rtl/bpa_ram.sv
// generic single-write, single-read ram with registered read data
module bpa_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/bpa_ctrl.sv
// sequencing state machine of the page allocator
module bpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  bpa_pkg::dp_status_t  status,
    output bpa_pkg::dp_cmd_t     cmd
);

    import bpa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = status.dma_alloc ? S_STEP : S_UPDATE;
            end
            S_STEP:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_LOOK:
            begin
                cmd.look = 1'b1;
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            S_DONE:
            begin
                cmd.load_out = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a result word is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result word dropped");

    // no request is taken before the clearing pass ends
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("request accepted during clearing pass");

    // a dma allocation always passes through the group lookup step
    a_step_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && status.dma_alloc) |-> $past(state_reg) == S_STEP)
        else $error("dma allocation skipped group lookup");

endmodule

// File: hw/rtl/bpa_dp.sv
// bitmap storage, summary bits and result datapath of the page allocator
module bpa_dp #(
    parameter int LOW_POOL_WORDS        = bpa_pkg::LOW_POOL_WORDS_DEF,
    parameter int DMA_POOL_WORDS        = bpa_pkg::DMA_POOL_WORDS_DEF,
    parameter int DMA_FIRST_SEARCH_WORD = bpa_pkg::DMA_FIRST_SEARCH_WORD_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bpa_pkg::dp_cmd_t                   cmd,
    output bpa_pkg::dp_status_t                status,
    input  logic                               operation,
    input  logic                               pool,
    input  logic [bpa_pkg::ADDR_W-1:0]         address,
    output logic [bpa_pkg::PAGE_ADDR_W-1:0]    page_address,
    output logic                               ok
);

    import bpa_pkg::*;

    localparam int NG    = (DMA_POOL_WORDS + MAP_W - 1) / MAP_W;
    localparam int LW_W  = $clog2(LOW_POOL_WORDS);
    localparam int DW_W  = $clog2(DMA_POOL_WORDS);
    localparam int NG_W  = (NG > 1) ? $clog2(NG) : 1;
    localparam int CLR_N = (LOW_POOL_WORDS > DMA_POOL_WORDS) ? LOW_POOL_WORDS : DMA_POOL_WORDS;
    localparam int CLR_W = $clog2(CLR_N);

    // request
    logic                   op_reg,   op_next;
    logic                   pool_reg, pool_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;

    // summary: one bit per nonempty low word, one bit per nonempty dma group
    logic [LOW_POOL_WORDS-1:0] low_sum_reg, low_sum_next;
    logic [NG-1:0]             grp_reg,     grp_next;
    logic [CLR_W-1:0]          clr_cnt_reg, clr_cnt_next;

    // lookup results
    logic                   hit_reg, hit_next;
    logic [LW_W-1:0]        lw_reg,  lw_next;
    logic [DW_W-1:0]        dw_reg,  dw_next;
    logic [NG_W-1:0]        g_reg,   g_next;
    logic [BIT_IDX_W-1:0]   s_reg,   s_next;
    logic [BIT_IDX_W-1:0]   bit_reg, bit_next;

    logic [PAGE_ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic                   res_ok_reg,   res_ok_next;
    logic [PAGE_ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic                   out_ok_reg,   out_ok_next;

    // ram ports
    logic              low_we, low_re;
    logic [LW_W-1:0]   low_wa, low_ra;
    logic [MAP_W-1:0]  low_wd, low_rd;
    logic              dma_we, dma_re;
    logic [DW_W-1:0]   dma_wa, dma_ra;
    logic [MAP_W-1:0]  dma_wd, dma_rd;
    logic              grp_we, grp_re;
    logic [NG_W-1:0]   grp_wa, grp_ra;
    logic [MAP_W-1:0]  grp_wd, grp_rd;

    // decode of the captured request
    logic [WORD_IDX_W-1:0] low_word, dma_word;
    logic [ADDR_W-1:0]     dma_off;
    logic [BIT_IDX_W-1:0]  low_first, grp_first, step_s;
    logic [NG_W+BIT_IDX_W-1:0] step_w;
    logic [BIT_IDX_W-1:0]  low_b, dma_b;
    logic [MAP_W-1:0]      low_clr, dma_clr, low_set, dma_set, grp_clr, grp_set;
    logic [LW_W+BIT_IDX_W-1:0] page_low;
    logic [DW_W+BIT_IDX_W-1:0] page_dma;
    logic [ADDR_W-1:0]     addr_low, addr_dma;
    logic [MAP_W-1:0]      grp_init;
    logic [ADDR_W-1:0]     clr_word;

    assign low_word  = addr_reg[ADDR_W-1:WORD_SHIFT];
    assign dma_off   = addr_reg - DMA_BASE;
    assign dma_word  = dma_off[ADDR_W-1:WORD_SHIFT];
    assign low_first = first_set64(MAP_W'(low_sum_reg));
    assign grp_first = first_set64(MAP_W'(grp_reg));
    assign step_s    = first_set64(grp_rd);
    assign step_w    = {g_reg, step_s};

    assign low_b   = first_set64(low_rd);
    assign dma_b   = first_set64(dma_rd);
    assign low_clr = low_rd & ~(MAP_W'(1) << low_b);
    assign dma_clr = dma_rd & ~(MAP_W'(1) << dma_b);
    assign low_set = low_rd | (MAP_W'(1) << bit_reg);
    assign dma_set = dma_rd | (MAP_W'(1) << bit_reg);
    assign grp_clr = grp_rd & ~(MAP_W'(1) << s_reg);
    assign grp_set = grp_rd | (MAP_W'(1) << s_reg);

    assign page_low = {lw_reg, low_b};
    assign page_dma = {dw_reg, dma_b};
    assign addr_low = ADDR_W'(page_low) << PAGE_SHIFT;
    assign addr_dma = (ADDR_W'(page_dma) << PAGE_SHIFT) + DMA_BASE;

    // reset content of one group summary word during the clearing pass
    always_comb
    begin
        grp_init = '0;
        for (int j = 0; j < MAP_W; j++)
        begin
            clr_word    = (ADDR_W'(clr_cnt_reg) << BIT_IDX_W) + ADDR_W'(j);
            grp_init[j] = (clr_word >= ADDR_W'(DMA_FIRST_SEARCH_WORD))
                       && (clr_word < ADDR_W'(DMA_POOL_WORDS));
        end
    end

    // request capture and lookup
    always_comb
    begin
        op_next   = op_reg;
        pool_next = pool_reg;
        addr_next = addr_reg;
        hit_next  = hit_reg;
        lw_next   = lw_reg;
        dw_next   = dw_reg;
        g_next    = g_reg;
        s_next    = s_reg;
        bit_next  = bit_reg;
        low_re    = 1'b0;
        low_ra    = lw_reg;
        dma_re    = 1'b0;
        dma_ra    = dw_reg;
        grp_re    = 1'b0;
        grp_ra    = g_reg;

        if (cmd.capture)
        begin
            op_next   = operation;
            pool_next = pool;
            addr_next = address;
        end

        if (cmd.look)
        begin
            if (op_reg == OP_ALLOC)
            begin
                if (pool_reg == POOL_LOW)
                begin
                    hit_next = |low_sum_reg;
                    lw_next  = low_first[LW_W-1:0];
                    low_re   = 1'b1;
                    low_ra   = low_first[LW_W-1:0];
                end
                else
                begin
                    hit_next = |grp_reg;
                    g_next   = grp_first[NG_W-1:0];
                    grp_re   = 1'b1;
                    grp_ra   = grp_first[NG_W-1:0];
                end
            end
            else
            begin
                if (pool_reg == POOL_LOW)
                begin
                    hit_next = (addr_reg < DMA_BASE)
                            && (ADDR_W'(low_word) < ADDR_W'(LOW_POOL_WORDS));
                    lw_next  = low_word[LW_W-1:0];
                    bit_next = addr_reg[WORD_SHIFT-1:PAGE_SHIFT];
                    low_re   = 1'b1;
                    low_ra   = low_word[LW_W-1:0];
                end
                else
                begin
                    hit_next = (addr_reg >= DMA_BASE)
                            && (ADDR_W'(dma_word) < ADDR_W'(DMA_POOL_WORDS));
                    dw_next  = dma_word[DW_W-1:0];
                    g_next   = dma_word[NG_W+BIT_IDX_W-1:BIT_IDX_W];
                    s_next   = dma_word[BIT_IDX_W-1:0];
                    bit_next = dma_off[WORD_SHIFT-1:PAGE_SHIFT];
                    dma_re   = 1'b1;
                    dma_ra   = dma_word[DW_W-1:0];
                    grp_re   = 1'b1;
                    grp_ra   = dma_word[NG_W+BIT_IDX_W-1:BIT_IDX_W];
                end
            end
        end

        // second level of the dma search: word inside the chosen group
        if (cmd.step)
        begin
            s_next  = step_s;
            dw_next = step_w[DW_W-1:0];
            dma_re  = 1'b1;
            dma_ra  = step_w[DW_W-1:0];
        end
    end

    // write-back, summary maintenance and clearing pass
    always_comb
    begin
        low_we        = 1'b0;
        low_wa        = lw_reg;
        low_wd        = low_clr;
        dma_we        = 1'b0;
        dma_wa        = dw_reg;
        dma_wd        = dma_clr;
        grp_we        = 1'b0;
        grp_wa        = g_reg;
        grp_wd        = grp_clr;
        low_sum_next  = low_sum_reg;
        grp_next      = grp_reg;
        clr_cnt_next  = clr_cnt_reg;
        res_addr_next = res_addr_reg;
        res_ok_next   = res_ok_reg;

        if (cmd.clear)
        begin
            clr_cnt_next = clr_cnt_reg + CLR_W'(1);
            low_we = ADDR_W'(clr_cnt_reg) < ADDR_W'(LOW_POOL_WORDS);
            low_wa = clr_cnt_reg[LW_W-1:0];
            low_wd = (clr_cnt_reg == '0) ? LOW_WORD0_RST : '1;
            dma_we = ADDR_W'(clr_cnt_reg) < ADDR_W'(DMA_POOL_WORDS);
            dma_wa = clr_cnt_reg[DW_W-1:0];
            dma_wd = '1;
            grp_we = ADDR_W'(clr_cnt_reg) < ADDR_W'(NG);
            grp_wa = clr_cnt_reg[NG_W-1:0];
            grp_wd = grp_init;
        end
        else if (cmd.update)
        begin
            res_addr_next = '0;
            res_ok_next   = hit_reg;
            if (hit_reg)
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (pool_reg == POOL_LOW)
                    begin
                        low_we = 1'b1;
                        low_sum_next[lw_reg] = |low_clr;
                        res_addr_next = addr_low[PAGE_ADDR_W-1:0];
                    end
                    else
                    begin
                        dma_we = 1'b1;
                        if (dma_clr == '0)
                        begin
                            grp_we = 1'b1;
                            grp_next[g_reg] = |grp_clr;
                        end
                        res_addr_next = addr_dma[PAGE_ADDR_W-1:0];
                    end
                end
                else
                begin
                    if (pool_reg == POOL_LOW)
                    begin
                        low_we = 1'b1;
                        low_wd = low_set;
                        low_sum_next[lw_reg] = 1'b1;
                    end
                    else
                    begin
                        dma_we = 1'b1;
                        dma_wd = dma_set;
                        if (ADDR_W'(dw_reg) >= ADDR_W'(DMA_FIRST_SEARCH_WORD))
                        begin
                            grp_we = 1'b1;
                            grp_wd = grp_set;
                            grp_next[g_reg] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_addr_next = out_addr_reg;
        out_ok_next   = out_ok_reg;
        if (cmd.load_out)
        begin
            out_addr_next = res_addr_reg;
            out_ok_next   = res_ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_sum_reg <= '1;
            grp_reg     <= '1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            low_sum_reg <= low_sum_next;
            grp_reg     <= grp_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pool_reg     <= pool_next;
        addr_reg     <= addr_next;
        hit_reg      <= hit_next;
        lw_reg       <= lw_next;
        dw_reg       <= dw_next;
        g_reg        <= g_next;
        s_reg        <= s_next;
        bit_reg      <= bit_next;
        res_addr_reg <= res_addr_next;
        res_ok_reg   <= res_ok_next;
        out_addr_reg <= out_addr_next;
        out_ok_reg   <= out_ok_next;
    end

    bpa_ram #(.WIDTH(MAP_W), .DEPTH(LOW_POOL_WORDS)) u_low_ram (
        .clk     (clk),
        .wr_en   (low_we),
        .wr_addr (low_wa),
        .wr_data (low_wd),
        .rd_en   (low_re),
        .rd_addr (low_ra),
        .rd_data (low_rd)
    );

    bpa_ram #(.WIDTH(MAP_W), .DEPTH(DMA_POOL_WORDS)) u_dma_ram (
        .clk     (clk),
        .wr_en   (dma_we),
        .wr_addr (dma_wa),
        .wr_data (dma_wd),
        .rd_en   (dma_re),
        .rd_addr (dma_ra),
        .rd_data (dma_rd)
    );

    bpa_ram #(.WIDTH(MAP_W), .DEPTH(NG)) u_grp_ram (
        .clk     (clk),
        .wr_en   (grp_we),
        .wr_addr (grp_wa),
        .wr_data (grp_wd),
        .rd_en   (grp_re),
        .rd_addr (grp_ra),
        .rd_data (grp_rd)
    );

    assign status.clear_last = (clr_cnt_reg == CLR_W'(CLR_N - 1));
    assign status.dma_alloc  = (op_reg == OP_ALLOC) && (pool_reg == POOL_DMA);
    assign page_address      = out_addr_reg;
    assign ok                = out_ok_reg;

    // summary says a low word is nonempty, so the word read back must be
    a_low_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && hit_reg && op_reg == OP_ALLOC && pool_reg == POOL_LOW)
        |-> low_rd != '0)
        else $error("low summary points at an empty word");

    // group summary word must name at least one nonempty dma word
    a_grp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && hit_reg) |-> grp_rd != '0)
        else $error("group summary bit set for an empty group");

    a_dma_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && hit_reg && op_reg == OP_ALLOC && pool_reg == POOL_DMA)
        |-> dma_rd != '0)
        else $error("dma summary points at an empty word");

    // a freed low page marks its word nonempty
    a_low_free_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && hit_reg && op_reg == OP_FREE && pool_reg == POOL_LOW)
        |=> low_sum_reg[$past(lw_reg)])
        else $error("low free did not mark summary");

endmodule
